// ===== hw/rtl/flac_metadata_parser_core_defines.svh =====
// Assertion macros used by the checker file of the metadata parser.
`ifndef FLAC_METADATA_PARSER_CORE_DEFINES_SVH
`define FLAC_METADATA_PARSER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmp assertion failed");

`endif

// ===== hw/rtl/fmp_pkg.sv =====
// Types, codes and constants of the FLAC metadata parser.
`default_nettype none
package fmp_pkg;

    localparam int SEEK_TABLE_CAPACITY = 5000;
    localparam int SEEK_CNT_W = $clog2(SEEK_TABLE_CAPACITY + 1);
    localparam int FIELD_DEPTH = 18;
    localparam int POS_W = $clog2(FIELD_DEPTH + 1);

    // Parser phases.
    localparam logic [2:0] PH_MARKER = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_INFO   = 3'd2;
    localparam logic [2:0] PH_SEEK   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_FINISH = 3'd5;
    localparam logic [2:0] PH_HALT   = 3'd6;

    // Result kinds.
    localparam logic [2:0] K_INFO     = 3'd0;
    localparam logic [2:0] K_SEEK     = 3'd1;
    localparam logic [2:0] K_DONE     = 3'd2;
    localparam logic [2:0] K_BADMARK  = 3'd3;
    localparam logic [2:0] K_BIGBLOCK = 3'd4;
    localparam logic [2:0] K_CHANNELS = 3'd5;
    localparam logic [2:0] K_NOINFO   = 3'd6;
    localparam logic [2:0] K_TRUNC    = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_OFFSET = 2'd0;
    localparam logic [1:0] REG_BLOCK_LIMIT  = 2'd1;
    localparam logic [1:0] REG_CHAN_LIMIT   = 2'd2;

    localparam logic [15:0] BLOCK_LIMIT_RST = 16'd4608;
    localparam logic [3:0]  CHAN_LIMIT_RST  = 4'd7;

    localparam logic [6:0] BT_STREAMINFO = 7'd0;
    localparam logic [6:0] BT_SEEKTABLE  = 7'd3;

    // "fLaC", entry 0 first on the wire.
    localparam logic [3:0][7:0] MARKER = {8'h43, 8'h61, 8'h4C, 8'h66};

    localparam int OUT_DATA_W = 176;

    typedef logic [FIELD_DEPTH-1:0][7:0] field_bytes_t;

    typedef struct packed {
        logic [31:0] start_offset;
        logic [15:0] block_size_limit;
        logic [3:0]  channel_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]            phase;
        logic [POS_W-1:0]      pos;
        logic [23:0]           remaining;
        logic                  last_block;
        logic [6:0]            block_type;
        logic [SEEK_CNT_W-1:0] seek_count;
        logic [31:0]           metadata_length;
        logic                  info_seen;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sample_position;
        logic [31:0] byte_offset;
        logic [15:0] block_size_low;
        logic [15:0] block_size_high;
        logic [23:0] frame_size_low;
        logic [23:0] frame_size_high;
        logic [19:0] sample_rate;
        logic [3:0]  channel_count;
        logic [5:0]  bits_per_sample;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fmp_step.sv =====
// Next-state and result logic for one byte of the metadata parser.
`default_nettype none
module fmp_step
    import fmp_pkg::*;
(
    input  parse_state_t cur,
    input  field_bytes_t fb,
    input  cfg_t         cfg,
    input  logic [7:0]   data_byte,
    input  logic         end_of_data,
    output parse_state_t nxt,
    output field_bytes_t fb_next,
    output logic         res_valid,
    output result_t      res
);

    logic             seek_full;
    logic             seek_skip;
    logic             wr_en;
    logic [POS_W-1:0] info_cnt;
    logic [23:0]      rem_dec;
    logic [23:0]      rem_hdr;
    field_bytes_t     fbm;
    logic [15:0]      maxbs;
    logic [3:0]       chans;
    logic             point_ok;
    logic             close_blk;
    logic             made;
    logic             do_final;
    logic             do_info;

    assign seek_full = cur.seek_count >= SEEK_CNT_W'(SEEK_TABLE_CAPACITY);
    assign seek_skip = (cur.pos == '0) && (seek_full || (cur.remaining < 24'd18));
    assign rem_dec   = cur.remaining - 24'd1;
    assign rem_hdr   = {cur.remaining[15:0], data_byte};

    always_comb
    begin
        wr_en = 1'b0;
        if (!end_of_data)
        begin
            if (cur.phase == PH_INFO)
                wr_en = cur.pos < POS_W'(FIELD_DEPTH);
            else if (cur.phase == PH_SEEK)
                wr_en = !seek_skip;
        end
        if (cur.phase == PH_INFO)
            info_cnt = (cur.pos < POS_W'(FIELD_DEPTH)) ? cur.pos + 1'b1 : cur.pos;
        else
            info_cnt = '0;
    end

    // Write the byte into its slot; unwritten stream-info bytes read as zero.
    always_comb
    begin
        for (int i = 0; i < FIELD_DEPTH; i++)
        begin
            fb_next[i] = (wr_en && (cur.pos == POS_W'(i))) ? data_byte : fb[i];
            fbm[i]     = (POS_W'(i) < info_cnt) ? fb_next[i] : 8'h00;
        end
    end

    assign maxbs = {fbm[2], fbm[3]};
    assign chans = {1'b0, fbm[12][3:1]} + 4'd1;
    assign point_ok = ({fb_next[0], fb_next[1], fb_next[2], fb_next[3]} == 32'd0)
                   && ({fb_next[4], fb_next[5], fb_next[6], fb_next[7]} != 32'hffffffff)
                   && ({fb_next[8], fb_next[9], fb_next[10], fb_next[11]} == 32'd0);

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        close_blk = 1'b0;
        made      = 1'b0;
        do_final  = 1'b0;
        do_info   = 1'b0;
        case (cur.phase)
            PH_HALT:
            begin
            end
            PH_FINISH:
                do_final = 1'b1;
            PH_MARKER, PH_HEADER, PH_INFO, PH_SEEK, PH_SKIP:
            begin
                if (end_of_data)
                begin
                    res_valid = 1'b1;
                    res.kind  = K_TRUNC;
                    nxt.phase = PH_HALT;
                end
                else
                begin
                    case (cur.phase)
                        PH_MARKER:
                        begin
                            if (data_byte != MARKER[cur.pos[1:0]])
                            begin
                                res_valid = 1'b1;
                                res.kind  = K_BADMARK;
                                nxt.phase = PH_HALT;
                            end
                            else if (cur.pos == POS_W'(3))
                            begin
                                nxt.pos             = '0;
                                nxt.metadata_length = cfg.start_offset + 32'd4;
                                nxt.phase           = PH_HEADER;
                            end
                            else
                                nxt.pos = cur.pos + 1'b1;
                        end
                        PH_HEADER:
                        begin
                            nxt.pos = cur.pos + 1'b1;
                            if (cur.pos == '0)
                            begin
                                nxt.last_block = data_byte[7];
                                nxt.block_type = data_byte[6:0];
                                nxt.remaining  = '0;
                            end
                            else
                                nxt.remaining = rem_hdr;
                            if (cur.pos == POS_W'(3))
                            begin
                                nxt.pos = '0;
                                nxt.metadata_length = cur.metadata_length
                                                    + {8'd0, rem_hdr} + 32'd4;
                                if (cur.block_type == BT_STREAMINFO)
                                begin
                                    nxt.phase = PH_INFO;
                                    do_info   = rem_hdr == 24'd0;
                                end
                                else
                                begin
                                    nxt.phase = (cur.block_type == BT_SEEKTABLE) ?
                                                PH_SEEK : PH_SKIP;
                                    close_blk = rem_hdr == 24'd0;
                                end
                            end
                        end
                        PH_INFO:
                        begin
                            nxt.pos       = info_cnt;
                            nxt.remaining = rem_dec;
                            do_info       = rem_dec == 24'd0;
                        end
                        PH_SEEK:
                        begin
                            nxt.remaining = rem_dec;
                            close_blk     = rem_dec == 24'd0;
                            if (seek_skip)
                                nxt.phase = PH_SKIP;
                            else if (cur.pos == POS_W'(FIELD_DEPTH - 1))
                            begin
                                nxt.pos = '0;
                                if (point_ok)
                                begin
                                    res_valid           = 1'b1;
                                    made                = 1'b1;
                                    res.kind            = K_SEEK;
                                    res.sample_position = {fb_next[4], fb_next[5],
                                                           fb_next[6], fb_next[7]};
                                    res.byte_offset     = {fb_next[12], fb_next[13],
                                                           fb_next[14], fb_next[15]};
                                    res.block_size_low  = {fb_next[16], fb_next[17]};
                                    nxt.seek_count      = cur.seek_count + 1'b1;
                                end
                            end
                            else
                                nxt.pos = cur.pos + 1'b1;
                        end
                        PH_SKIP:
                        begin
                            nxt.remaining = rem_dec;
                            close_blk     = rem_dec == 24'd0;
                        end
                        default:
                            nxt.phase = PH_HALT;
                    endcase
                end
            end
            default:
                nxt.phase = PH_HALT;
        endcase

        // Stream information closes with range checks.
        if (do_info)
        begin
            res_valid = 1'b1;
            if (maxbs > cfg.block_size_limit)
            begin
                res.kind  = K_BIGBLOCK;
                nxt.phase = PH_HALT;
            end
            else if (chans > cfg.channel_limit)
            begin
                res.kind  = K_CHANNELS;
                nxt.phase = PH_HALT;
            end
            else
            begin
                res.kind            = K_INFO;
                res.sample_position = {fbm[14], fbm[15], fbm[16], fbm[17]};
                res.block_size_low  = {fbm[0], fbm[1]};
                res.block_size_high = maxbs;
                res.frame_size_low  = {fbm[4], fbm[5], fbm[6]};
                res.frame_size_high = {fbm[7], fbm[8], fbm[9]};
                res.sample_rate     = {fbm[10], fbm[11], fbm[12][7:4]};
                res.channel_count   = chans;
                res.bits_per_sample = {1'b0, fbm[12][0], fbm[13][7:4]} + 6'd1;
                nxt.info_seen       = 1'b1;
                close_blk           = 1'b1;
                made                = 1'b1;
            end
        end

        // Close the block: next header, deferred final, or final now.
        if (close_blk)
        begin
            nxt.pos = '0;
            if (!cur.last_block)
                nxt.phase = PH_HEADER;
            else if (made)
                nxt.phase = PH_FINISH;
            else
                do_final = 1'b1;
        end

        if (do_final)
        begin
            res_valid = 1'b1;
            res       = '0;
            nxt.phase = PH_HALT;
            if (cur.info_seen)
            begin
                res.kind        = K_DONE;
                res.byte_offset = nxt.metadata_length;
            end
            else
                res.kind = K_NOINFO;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/flac_metadata_parser_core.sv =====
// Top level of the FLAC metadata parser: channels, state and result register.
//
// Usage:
//   s_axis carries one file byte per transaction, starting at the "fLaC"
//   marker; tuser set marks end of data (the byte is then ignored).
//   m_axis carries zero or one result per input byte: tuser is the kind,
//   tdata the stream-info, seek-point or length fields (zero where unused).
//   cfg carries register writes (index 0 start offset, 1 block size limit,
//   2 channel limit); it is always ready and should be used only while idle.
// Throughput:
//   One byte per cycle while m_axis is not stalled. A result appears on m_axis
//   in the cycle after the byte that causes it; the whole step is one pass
//   of logic between the parser state and the output register.
// Stall:
//   The output register holds a result until m_axis_tready; s_axis_tready
//   stays high while that register is empty or being drained that cycle.
// Reset:
//   rst_n clears the parser to the marker check, drops any pending result
//   and restores the register defaults (4608 block size, 7 channels).
//   After a halting result (done or any error) no results follow until reset.
`default_nettype none
module flac_metadata_parser_core
    import fmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] end_of_data
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] sample_position, [63:32] byte_offset, [79:64] block_size_low,
    // [95:80] block_size_high, [119:96] frame_size_low,
    // [143:120] frame_size_high, [163:144] sample_rate,
    // [167:164] channel_count, [173:168] bits_per_sample, [175:174] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [2:0]            m_axis_tuser,   // [2:0] kind
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    cfg_t         cfg_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    field_bytes_t fb_reg;
    field_bytes_t fb_next;
    logic         res_valid;
    result_t      res;
    logic         out_valid_reg;
    result_t      out_reg;
    logic         in_xfer;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Configuration registers: take every write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= {32'd0, BLOCK_LIMIT_RST, CHAN_LIMIT_RST};
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_OFFSET: cfg_reg.start_offset     <= cfg_data;
                REG_BLOCK_LIMIT:  cfg_reg.block_size_limit <= cfg_data[15:0];
                REG_CHAN_LIMIT:   cfg_reg.channel_limit    <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    fmp_step u_step (
        .cur         (state_reg),
        .fb          (fb_reg),
        .cfg         (cfg_reg),
        .data_byte   (s_axis_tdata),
        .end_of_data (s_axis_tuser),
        .nxt         (state_next),
        .fb_next     (fb_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Parser state advances only on an accepted input transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            // marker check, everything clear, length at four
            state_reg <= {PH_MARKER, {POS_W{1'b0}}, 24'd0, 1'b0, 7'd0,
                          {SEEK_CNT_W{1'b0}}, 32'd4, 1'b0};
        else if (in_xfer)
            state_reg <= state_next;
    end

    // Field bytes are payload: defined only once written.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            fb_reg <= fb_next;
    end

    // Output register: load a new result, or drop the old one once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= res_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {2'b00,
                            out_reg.bits_per_sample,
                            out_reg.channel_count,
                            out_reg.sample_rate,
                            out_reg.frame_size_high,
                            out_reg.frame_size_low,
                            out_reg.block_size_high,
                            out_reg.block_size_low,
                            out_reg.byte_offset,
                            out_reg.sample_position};

endmodule
`default_nettype wire

// ===== hw/rtl/fmp_checker.sv =====
// Port-level checker of the metadata parser and its bind.
`default_nettype none
`include "flac_metadata_parser_core_defines.svh"
module fmp_checker
    import fmp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [2:0]            m_axis_tuser
);

    logic halt_xfer;
    logic info_out;
    logic info_ok;

    assign halt_xfer = m_axis_tvalid && m_axis_tready
                    && (m_axis_tuser != K_INFO) && (m_axis_tuser != K_SEEK);
    assign info_out  = m_axis_tvalid && (m_axis_tuser == K_INFO);
    assign info_ok   = info_out ?
                       (m_axis_tdata[167:164] != 4'd0 && m_axis_tdata[173:168] != 6'd0) :
                       (m_axis_tdata[173:164] == 10'd0);

    // A stalled result holds.
    `FMP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}))
    // Input back-pressure only comes from a stalled result.
    `FMP_ASSERT_NOW(a_ready, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    // Nothing follows a halting result.
    `FMP_ASSERT_NEXT(a_halt, halt_xfer, !m_axis_tvalid)
    // Channel count and bit depth show only on stream info, never zero there.
    `FMP_ASSERT_NOW(a_info, m_axis_tvalid, info_ok)

endmodule

bind flac_metadata_parser_core fmp_checker u_fmp_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the FLAC metadata parser: file streams, register writes, prediction and checks.
`timescale 1ns / 1ps

module tb_top;
    import fmp_pkg::*;

    // One byte of the file, with the report typed in by hand where it is obvious.
    typedef struct packed {
        logic [7:0] data;
        logic       eod;
        logic       fixed;
        result_t    want;
    } file_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fixed;
        result_t    want;
    } opening_row_t;

    localparam result_t NO_REPORT = '0;
    // Empty stream info: every byte reads as zero, only the plus-one fields show.
    localparam result_t EMPTY_INFO =
        '{K_INFO, 32'd0, 32'd0, 16'd0, 16'd0, 24'd0, 24'd0, 20'd0, 4'd1, 6'd1};
    // Fourteen 0xff bytes: every field at its top, total samples missing.
    localparam result_t FULL_INFO =
        '{K_INFO, 32'd0, 32'd0, 16'hffff, 16'hffff, 24'hffffff, 24'hffffff,
          20'hfffff, 4'd8, 6'd32};

    localparam int OPENING_ROWS = 26;
    localparam opening_row_t OPENING [OPENING_ROWS] = '{
        '{MARKER[0], 1'b0, NO_REPORT},
        '{MARKER[1], 1'b0, NO_REPORT},
        '{MARKER[2], 1'b0, NO_REPORT},
        '{MARKER[3], 1'b0, NO_REPORT},
        '{{1'b0, BT_STREAMINFO}, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b1, EMPTY_INFO},
        '{{1'b0, BT_STREAMINFO}, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h0e, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b0, NO_REPORT},
        '{8'hff, 1'b1, FULL_INFO}
    };

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'd0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = 2'd0;
    logic [31:0]           cfg_data = 32'd0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;

    file_item_t file_bytes[$];
    result_t    due_reports[$];

    // Own copy of the register file.
    logic [31:0] lim_start;
    logic [15:0] lim_block;
    logic [3:0]  lim_chan;

    // Own copy of the parser state.
    logic [2:0]  walk_phase;
    logic [4:0]  walk_pos;
    logic [23:0] walk_left;
    logic        walk_last;
    logic [6:0]  walk_type;
    logic [7:0]  walk_fields [0:17];
    int          seeks_taken;
    logic [31:0] meta_len;
    logic        info_found;

    flac_metadata_parser_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    task automatic walk_reset();
        lim_start   = 32'd0;
        lim_block   = BLOCK_LIMIT_RST;
        lim_chan    = CHAN_LIMIT_RST;
        walk_phase  = PH_MARKER;
        walk_pos    = '0;
        walk_left   = '0;
        walk_last   = 1'b0;
        walk_type   = '0;
        seeks_taken = 0;
        meta_len    = 32'd4;
        info_found  = 1'b0;
    endtask

    function automatic logic [31:0] field_word(input int at);
        return {walk_fields[at], walk_fields[at+1], walk_fields[at+2], walk_fields[at+3]};
    endfunction

    function automatic result_t final_report();
        result_t r;
        r = '0;
        if (info_found)
        begin
            r.kind = K_DONE;
            r.byte_offset = meta_len;
        end
        else
            r.kind = K_NOINFO;
        return r;
    endfunction

    // Advance the parser copy by one accepted byte; got marks a report.
    task automatic walk_byte(input logic [7:0] b, input logic eod,
                             output bit got, output result_t rep);
        logic [15:0] max_bs;
        logic [3:0]  chans;
        bit          info_end;
        bit          block_end;
        int          i;
        got = 1'b0;
        rep = '0;
        info_end = 1'b0;
        block_end = 1'b0;
        if (walk_phase == PH_HALT)
        begin
            // halted: nothing until reset
        end
        else if (walk_phase == PH_FINISH)
        begin
            rep = final_report();
            walk_phase = PH_HALT;
            got = 1'b1;
        end
        else if (eod)
        begin
            rep.kind = K_TRUNC;
            walk_phase = PH_HALT;
            got = 1'b1;
        end
        else
        begin
            case (walk_phase)
                PH_MARKER:
                begin
                    if (b != MARKER[walk_pos[1:0]])
                    begin
                        rep.kind = K_BADMARK;
                        walk_phase = PH_HALT;
                        got = 1'b1;
                    end
                    else
                    begin
                        walk_pos = walk_pos + 5'd1;
                        if (walk_pos == 5'd4)
                        begin
                            walk_pos = '0;
                            meta_len = lim_start + 32'd4;
                            walk_phase = PH_HEADER;
                        end
                    end
                end
                PH_HEADER:
                begin
                    if (walk_pos == 5'd0)
                    begin
                        walk_last = b[7];
                        walk_type = b[6:0];
                        walk_left = '0;
                    end
                    else
                        walk_left = {walk_left[15:0], b};
                    walk_pos = walk_pos + 5'd1;
                    if (walk_pos == 5'd4)
                    begin
                        walk_pos = '0;
                        meta_len = meta_len + {8'd0, walk_left} + 32'd4;
                        if (walk_type == BT_STREAMINFO)
                        begin
                            for (i = 0; i < 18; i++)
                                walk_fields[i] = 8'd0;
                            walk_phase = PH_INFO;
                            info_end = (walk_left == 24'd0);
                        end
                        else
                        begin
                            walk_phase = (walk_type == BT_SEEKTABLE) ? PH_SEEK : PH_SKIP;
                            block_end = (walk_left == 24'd0);
                        end
                    end
                end
                PH_INFO:
                begin
                    if (walk_pos < 5'd18)
                    begin
                        walk_fields[walk_pos] = b;
                        walk_pos = walk_pos + 5'd1;
                    end
                    walk_left = walk_left - 24'd1;
                    info_end = (walk_left == 24'd0);
                end
                PH_SEEK:
                begin
                    if (walk_pos == 5'd0 &&
                        (seeks_taken >= SEEK_TABLE_CAPACITY || walk_left < 24'd18))
                    begin
                        // table full or a partial point: skip the rest of the block
                        walk_phase = PH_SKIP;
                        walk_left = walk_left - 24'd1;
                        block_end = (walk_left == 24'd0);
                    end
                    else
                    begin
                        walk_fields[walk_pos] = b;
                        walk_pos = walk_pos + 5'd1;
                        walk_left = walk_left - 24'd1;
                        if (walk_pos == 5'd18)
                        begin
                            walk_pos = '0;
                            if (field_word(0) == 32'd0 && field_word(4) != 32'hffffffff &&
                                field_word(8) == 32'd0)
                            begin
                                rep.kind = K_SEEK;
                                rep.sample_position = field_word(4);
                                rep.byte_offset = field_word(12);
                                rep.block_size_low = {walk_fields[16], walk_fields[17]};
                                seeks_taken++;
                                got = 1'b1;
                            end
                        end
                        block_end = (walk_left == 24'd0);
                    end
                end
                PH_SKIP:
                begin
                    walk_left = walk_left - 24'd1;
                    block_end = (walk_left == 24'd0);
                end
                default:
                    walk_phase = PH_HALT;
            endcase
        end

        if (info_end)
        begin
            max_bs = {walk_fields[2], walk_fields[3]};
            chans = {1'b0, walk_fields[12][3:1]} + 4'd1;
            if (max_bs > lim_block)
            begin
                rep.kind = K_BIGBLOCK;
                walk_phase = PH_HALT;
                got = 1'b1;
            end
            else if (chans > lim_chan)
            begin
                rep.kind = K_CHANNELS;
                walk_phase = PH_HALT;
                got = 1'b1;
            end
            else
            begin
                rep.kind = K_INFO;
                rep.sample_position = field_word(14);
                rep.block_size_low = {walk_fields[0], walk_fields[1]};
                rep.block_size_high = max_bs;
                rep.frame_size_low = {walk_fields[4], walk_fields[5], walk_fields[6]};
                rep.frame_size_high = {walk_fields[7], walk_fields[8], walk_fields[9]};
                rep.sample_rate = {walk_fields[10], walk_fields[11], walk_fields[12][7:4]};
                rep.channel_count = chans;
                rep.bits_per_sample = {1'b0, walk_fields[12][0], walk_fields[13][7:4]} + 6'd1;
                info_found = 1'b1;
                got = 1'b1;
                block_end = 1'b1;
            end
        end

        if (block_end)
        begin
            walk_pos = '0;
            if (!walk_last)
                walk_phase = PH_HEADER;
            else if (got)
                walk_phase = PH_FINISH;   // done report waits for the next byte
            else
            begin
                rep = final_report();
                walk_phase = PH_HALT;
                got = 1'b1;
            end
        end
    endtask

    // ---------------------------------------------------------------- file builder

    task automatic add_item(input logic [7:0] b, input logic eod);
        file_item_t it;
        it = '0;
        it.data = b;
        it.eod = eod;
        file_bytes.push_back(it);
    endtask

    task automatic add_header(input logic last, input logic [6:0] code, input logic [23:0] len);
        add_item({last, code}, 1'b0);
        add_item(len[23:16], 1'b0);
        add_item(len[15:8], 1'b0);
        add_item(len[7:0], 1'b0);
    endtask

    task automatic add_info(input logic last, input int len, input logic [15:0] max_bs,
                            input logic [2:0] chm1);
        logic [7:0] f [0:17];
        int i;
        for (i = 0; i < 18; i++)
            f[i] = 8'($urandom);
        f[2] = max_bs[15:8];
        f[3] = max_bs[7:0];
        f[12][3:1] = chm1;
        add_header(last, BT_STREAMINFO, 24'(len));
        for (i = 0; i < len; i++)
            add_item((i < 18) ? f[i] : 8'($urandom), 1'b0);
    endtask

    task automatic add_point(input bit usable);
        logic [31:0]  hi;
        logic [31:0]  lo;
        logic [31:0]  ohi;
        logic [143:0] pt;
        int i;
        hi = 32'd0;
        ohi = 32'd0;
        lo = $urandom;
        if (lo == 32'hffffffff)
            lo = 32'd0;
        if (!usable)
        begin
            case ($urandom_range(2, 0))
                0:       hi = $urandom | 32'd1 << $urandom_range(31, 0);
                1:       ohi = $urandom | 32'd1 << $urandom_range(31, 0);
                default: lo = 32'hffffffff;
            endcase
        end
        pt = {hi, lo, ohi, 32'($urandom), 16'($urandom)};
        for (i = 0; i < 18; i++)
            add_item(pt[143 - 8*i -: 8], 1'b0);
    endtask

    function automatic int chan_top();
        return (lim_chan >= 4'd8) ? 7 : int'(lim_chan) - 1;
    endfunction

    // One non-last block that passes the current limits.
    task automatic add_random_block();
        int pick;
        int len;
        int n;
        int rem;
        int i;
        logic [6:0] code;
        pick = $urandom_range(99, 0);
        if (pick < 25)
        begin
            n = $urandom_range(99, 0);
            len = (n < 70) ? 34 : (n < 85) ? $urandom_range(17, 0) : $urandom_range(60, 18);
            add_info(1'b0, len, 16'($urandom_range(lim_block, 0)),
                     3'($urandom_range(chan_top(), 0)));
        end
        else if (pick < 60)
        begin
            n = $urandom_range(4, 0);
            rem = $urandom_range(1, 0) ? 0 : $urandom_range(17, 1);
            add_header(1'b0, BT_SEEKTABLE, 24'(18 * n + rem));
            for (i = 0; i < n; i++)
                add_point($urandom_range(99, 0) < 70);
            for (i = 0; i < rem; i++)
                add_item(8'($urandom), 1'b0);
        end
        else
        begin
            code = 7'($urandom_range(127, 1));
            if (code == BT_SEEKTABLE)
                code = code + 7'd1;
            len = (pick < 63) ? $urandom_range(700, 256) : $urandom_range(40, 0);
            add_header(1'b0, code, 24'(len));
            for (i = 0; i < len; i++)
                add_item(8'($urandom), 1'b0);
        end
    endtask

    // ---------------------------------------------------------------- channels

    task automatic send_file();
        file_item_t it;
        bit         got;
        result_t    rep;
        while (file_bytes.size() != 0)
        begin
            it = file_bytes.pop_front();
            while ($urandom_range(99, 0) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= it.data;
            s_axis_tuser <= it.eod;
            do @(posedge clk); while (!s_axis_tready);
            walk_byte(it.data, it.eod, got, rep);
            if (it.fixed)
            begin
                got = 1'b1;
                rep = it.want;
            end
            if (got)
                due_reports.push_back(rep);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_START_OFFSET: lim_start = value;
            REG_BLOCK_LIMIT:  lim_block = value[15:0];
            REG_CHAN_LIMIT:   lim_chan = value[3:0];
            default: ;
        endcase
    endtask

    task automatic write_regs(input logic [31:0] start, input logic [15:0] block_lim,
                              input logic [3:0] chan_lim);
        put_reg(REG_START_OFFSET, start);
        put_reg(REG_BLOCK_LIMIT, {16'd0, block_lim});
        put_reg(REG_CHAN_LIMIT, {28'd0, chan_lim});
        cfg_valid <= 1'b0;
    endtask

    // Wait out every pending report, then wait for a byte still in flight.
    task automatic settle();
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_start();
        case ($urandom_range(2, 0))
            0:       return 32'd0;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_fail(input string msg);
        fail_count++;
        $display("%s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
            report_fail($sformatf("%0t %s: expected %0h, got %0h", $time, name, want, seen));
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);

    always @(posedge clk)
    begin : watch_reports
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_reports.size() == 0)
                report_fail($sformatf("%0t report: expected none, got kind %0d data %0h",
                                      $time, m_axis_tuser, m_axis_tdata));
            else
            begin
                want = due_reports.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("sample_position", want.sample_position, m_axis_tdata[31:0]);
                check_field("byte_offset", want.byte_offset, m_axis_tdata[63:32]);
                check_field("block_size_low", 32'(want.block_size_low),
                            32'(m_axis_tdata[79:64]));
                check_field("block_size_high", 32'(want.block_size_high),
                            32'(m_axis_tdata[95:80]));
                check_field("frame_size_low", 32'(want.frame_size_low),
                            32'(m_axis_tdata[119:96]));
                check_field("frame_size_high", 32'(want.frame_size_high),
                            32'(m_axis_tdata[143:120]));
                check_field("sample_rate", 32'(want.sample_rate),
                            32'(m_axis_tdata[163:144]));
                check_field("channel_count", 32'(want.channel_count),
                            32'(m_axis_tdata[167:164]));
                check_field("bits_per_sample", 32'(want.bits_per_sample),
                            32'(m_axis_tdata[173:168]));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : run
        int i;
        int rem;
        int ending;
        walk_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: slow receiver; top limits so the all-ones stream info passes.
        send_idle_pct = 32;
        recv_idle_pct = 86;
        write_regs(pick_start(), 16'hffff, 4'd8);
        for (i = 0; i < OPENING_ROWS; i++)
            file_bytes.push_back('{OPENING[i].data, 1'b0, OPENING[i].fixed, OPENING[i].want});
        while (file_bytes.size() < 620)
            add_random_block();
        send_file();
        settle();

        // Phase two: slow sender; tight limits.
        write_regs(pick_start(), 16'd1, 4'd1);
        send_idle_pct = 86;
        recv_idle_pct = 32;
        while (file_bytes.size() < 600)
            add_random_block();
        send_file();
        settle();

        // Phase three: no idling; limits that leave room for both limit errors.
        write_regs($urandom, 16'($urandom_range(65534, 1)), 4'($urandom_range(7, 1)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (file_bytes.size() < 300)
            add_random_block();

        // Close the file one of several ways.
        ending = $urandom_range(4, 0);
        case (ending)
            0:
            begin
                rem = $urandom_range(5, 0);
                add_header(1'b1, 7'($urandom_range(127, 4)), 24'(rem));
                for (i = 0; i < rem; i++)
                    add_item(8'($urandom), 1'b0);
            end
            1:
            begin
                // last block reports itself, so done follows on the next byte
                add_info(1'b1, 34, 16'($urandom_range(lim_block, 0)),
                         3'($urandom_range(chan_top(), 0)));
                add_item(8'($urandom), 1'($urandom_range(1, 0)));
            end
            2:
                add_info(1'($urandom_range(1, 0)), 34,
                         16'($urandom_range(65535, int'(lim_block) + 1)),
                         3'($urandom_range(chan_top(), 0)));
            3:
                add_info(1'($urandom_range(1, 0)), 34, 16'($urandom_range(lim_block, 0)),
                         3'($urandom_range(7, int'(lim_chan))));
            default:
            begin
                // end of data in the middle of a block
                add_header(1'b0, 7'($urandom_range(127, 4)), 24'd20);
                rem = $urandom_range(19, 0);
                for (i = 0; i < rem; i++)
                    add_item(8'($urandom), 1'b0);
                add_item(8'($urandom), 1'b1);
            end
        endcase

        // The parser has halted: these must produce nothing.
        add_item(8'($urandom), 1'b1);
        for (i = 0; i < 5; i++)
            add_item(8'($urandom), 1'($urandom_range(1, 0)));
        send_file();
        settle();

        if (due_reports.size() != 0)
            report_fail($sformatf("%0t %0d reports never arrived", $time, due_reports.size()));
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
